// ----- design/gpcc_pkg.sv -----
// ---------------------------------------------------------------------------
// gpcc_pkg
// Shared types and constants for the gait phase contact classifier.
// ---------------------------------------------------------------------------
package gpcc_pkg;

  localparam int TimeW  = 63;
  localparam int WinW   = 24;
  localparam int PhaseW = 4;
  localparam int CfgIdxW = 8;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [WinW-1:0]   win_t;

  // Gait phases: left primary 0-3, right primary 4-7, unknown 8.
  localparam phase_t PH_L_STAND  = 4'd0;
  localparam phase_t PH_L_BREAK  = 4'd1;
  localparam phase_t PH_L_SWING  = 4'd2;
  localparam phase_t PH_L_STRIKE = 4'd3;
  localparam phase_t PH_R_STAND  = 4'd4;
  localparam phase_t PH_R_BREAK  = 4'd5;
  localparam phase_t PH_R_SWING  = 4'd6;
  localparam phase_t PH_R_STRIKE = 4'd7;
  localparam phase_t PH_UNKNOWN  = 4'd8;

  // Odometry quality codes.
  localparam logic [1:0] QUAL_ACCURATE   = 2'd0;
  localparam logic [1:0] QUAL_UNUSABLE   = 2'd1;
  localparam logic [1:0] QUAL_INACCURATE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_STRIKE_BLACKOUT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_BREAK_BLACKOUT  = 8'd1;

  localparam win_t STRIKE_BLACKOUT_RST = 24'd95000;
  localparam win_t BREAK_BLACKOUT_RST  = 24'd800000;

  // Contact flags of one sample.
  typedef struct packed {
    logic l;   // left weak
    logic r;   // right weak
    logic ls;  // left strong
    logic rs;  // right strong
  } contact_t;

  // Outcome of one phase step.
  typedef struct packed {
    phase_t phase;
    logic   strike_evt;
    logic   break_evt;
    logic   bad;
  } step_t;

endpackage

// ----- design/gait_phase_contact_classifier_core.sv -----
// ---------------------------------------------------------------------------
// gait_phase_contact_classifier_core
// Biped gait phase tracker and odometry quality classifier.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per sample: a 63-bit microsecond timestamp
//   and four contact flags. m_axis returns one result per request: odometry
//   quality, gait phase, recent-event flags per foot and an error flag for
//   an unlisted flag combination (the phase and event times then hold).
//   cfg_* writes the strike and break blackout windows; write it only while
//   no request is in flight. cfg_ready is always high; unknown indexes drop.
// Timing:
//   The result is registered: an input register, then the phase step and
//   two 63-bit window compares feed the result register. One request per
//   cycle sustained while m_axis_tready stays high; the phase and event-time
//   registers close their loop within the result stage.
// Reset (rst, synchronous): phase goes to unknown, event times to zero,
//   windows to 95000 us and 800000 us, both pipeline stages empty.
// Stall: while m_axis_tready is low the result holds and the input stage
//   fills; s_axis_tready drops only once both stages hold a request.
// ---------------------------------------------------------------------------
module gait_phase_contact_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [62:0] time_us, [63] left_weak, [64] right_weak, [65] left_strong,
  // [66] right_strong, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] odometry_quality, [5:2] gait_phase, [6] recent_left_event,
  // [7] recent_right_event, [8] unexpected_combination, [15:9] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gpcc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gpcc_pkg::WinW-1:0]    cfg_data
);

  // Configuration windows.
  gpcc_pkg::win_t strike_win;
  gpcc_pkg::win_t break_win;

  // Tracker state.
  gpcc_pkg::phase_t phase;
  gpcc_pkg::time_t  last_strike;
  gpcc_pkg::time_t  last_break;

  // Input stage.
  logic               in_valid;
  gpcc_pkg::time_t    in_time;
  gpcc_pkg::contact_t in_flags;

  // Result stage.
  logic        out_valid;
  logic [15:0] out_data;

  logic             stage_go;
  gpcc_pkg::step_t  step;
  gpcc_pkg::time_t  last_strike_next;
  gpcc_pkg::time_t  last_break_next;
  gpcc_pkg::time_t  strike_age;
  gpcc_pkg::time_t  break_age;
  logic             in_strike;
  logic             in_break;
  logic             right_side;
  logic             any_evt;
  logic [1:0]       quality;
  logic [15:0]      out_data_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strike_win <= gpcc_pkg::STRIKE_BLACKOUT_RST;
      break_win  <= gpcc_pkg::BREAK_BLACKOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gpcc_pkg::REG_STRIKE_BLACKOUT: strike_win <= cfg_data;
        gpcc_pkg::REG_BREAK_BLACKOUT:  break_win  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result register is free or drains.
  assign stage_go      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_time     <= s_axis_tdata[62:0];
      in_flags.l  <= s_axis_tdata[63];
      in_flags.r  <= s_axis_tdata[64];
      in_flags.ls <= s_axis_tdata[65];
      in_flags.rs <= s_axis_tdata[66];
    end
  end

  gpcc_phase_step u_step (
    .phase (phase),
    .c     (in_flags),
    .step  (step)
  );

  // Event times as they stand after this sample's transition.
  assign last_strike_next = step.strike_evt ? in_time : last_strike;
  assign last_break_next  = step.break_evt  ? in_time : last_break;

  // A timestamp earlier than the stored event counts as inside the window.
  assign strike_age = in_time - last_strike_next;
  assign break_age  = in_time - last_break_next;
  assign in_strike  = (in_time < last_strike_next) ||
                      (strike_age < {{(gpcc_pkg::TimeW-gpcc_pkg::WinW){1'b0}}, strike_win});
  assign in_break   = (in_time < last_break_next) ||
                      (break_age < {{(gpcc_pkg::TimeW-gpcc_pkg::WinW){1'b0}}, break_win});

  // Events are credited to the non-primary foot.
  assign right_side = step.phase < gpcc_pkg::PH_R_STAND;
  assign any_evt    = in_strike || in_break;
  assign quality    = in_strike ? gpcc_pkg::QUAL_UNUSABLE :
                      in_break  ? gpcc_pkg::QUAL_INACCURATE : gpcc_pkg::QUAL_ACCURATE;

  assign out_data_next = {7'd0, step.bad, any_evt && right_side,
                          any_evt && !right_side, step.phase, quality};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= gpcc_pkg::PH_UNKNOWN;
      last_strike <= '0;
      last_break  <= '0;
      out_valid   <= 1'b0;
    end else if (stage_go) begin
      out_valid <= in_valid;
      if (in_valid) begin
        phase       <= step.phase;
        last_strike <= last_strike_next;
        last_break  <= last_break_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && in_valid) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // An error result never moves the phase.
  a_bad_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (stage_go && in_valid && step.bad) |=> (phase == $past(phase)))
    else $error("phase moved on an unlisted combination");

  // Once out of unknown, the tracker never returns there.
  a_no_return_unknown: assert property (@(posedge clk) disable iff (rst)
    (phase != gpcc_pkg::PH_UNKNOWN) |=> (phase != gpcc_pkg::PH_UNKNOWN))
    else $error("phase returned to unknown");

  // A recent event is credited to one foot only.
  a_one_foot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[6] && out_data[7]))
    else $error("event credited to both feet");

  // Degraded quality goes with exactly one recent-event flag.
  a_quality_evt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data[1:0] != gpcc_pkg::QUAL_ACCURATE) ==
                   (out_data[6] || out_data[7])))
    else $error("quality and event flags disagree");

endmodule

// ----- design/gpcc_phase_step.sv -----
// ---------------------------------------------------------------------------
// gpcc_phase_step
// Next-phase logic of the gait phase machine, with event and error flags.
// ---------------------------------------------------------------------------
module gpcc_phase_step (
  input  gpcc_pkg::phase_t   phase,
  input  gpcc_pkg::contact_t c,
  output gpcc_pkg::step_t    step
);

  always_comb begin
    step.phase      = phase;
    step.strike_evt = 1'b0;
    step.break_evt  = 1'b0;
    step.bad        = 1'b0;
    case (phase)
      gpcc_pkg::PH_L_STAND: begin
        if (c.l && !c.rs) begin
          step.phase = gpcc_pkg::PH_L_BREAK;
          step.break_evt = 1'b1;
        end else if (!c.ls && c.r) begin
          step.phase = gpcc_pkg::PH_R_BREAK;
          step.break_evt = 1'b1;
        end else if (!(c.l && c.r)) begin
          step.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_L_BREAK: begin
        if (c.l && !c.r) step.phase = gpcc_pkg::PH_L_SWING;
        else if (c.l && c.rs) step.phase = gpcc_pkg::PH_L_STAND;
        else if (!c.l) step.bad = 1'b1;
      end
      gpcc_pkg::PH_L_SWING: begin
        if (c.l && c.r) begin
          step.phase = gpcc_pkg::PH_L_STRIKE;
          step.strike_evt = 1'b1;
        end else if (!c.l) begin
          step.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_L_STRIKE: begin
        if (c.l && c.rs) step.phase = gpcc_pkg::PH_L_STAND;
        else if (!c.l) step.bad = 1'b1;
      end
      gpcc_pkg::PH_R_STAND: begin
        if (!c.ls && c.r) begin
          step.phase = gpcc_pkg::PH_R_BREAK;
          step.break_evt = 1'b1;
        end else if (c.l && !c.rs) begin
          step.phase = gpcc_pkg::PH_L_BREAK;
          step.break_evt = 1'b1;
        end else if (!(c.l && c.r)) begin
          step.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_R_BREAK: begin
        if (!c.l && c.r) step.phase = gpcc_pkg::PH_R_SWING;
        else if (c.ls && c.r) step.phase = gpcc_pkg::PH_R_STAND;
        else if (!c.r) step.bad = 1'b1;
      end
      gpcc_pkg::PH_R_SWING: begin
        if (c.l && c.r) begin
          step.phase = gpcc_pkg::PH_R_STRIKE;
          step.strike_evt = 1'b1;
        end else if (!c.r) begin
          step.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_R_STRIKE: begin
        if (c.ls && c.r) step.phase = gpcc_pkg::PH_R_STAND;
        else if (!c.r) step.bad = 1'b1;
      end
      default: begin
        // Unknown: wait for both feet down; never an error.
        if (c.l && c.r) step.phase = gpcc_pkg::PH_L_STAND;
      end
    endcase
  end

endmodule

// ----- test/gait_result_checker.sv -----
// ---------------------------------------------------------------------------
// gait_result_checker
// Passive checker for the gait phase contact classifier: watches the request,
// result and register write channels, predicts every result and compares it.
// ---------------------------------------------------------------------------
module gait_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [71:0]                  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [15:0]                  m_axis_tdata,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [gpcc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gpcc_pkg::WinW-1:0]    cfg_data,
  output int                           pending,
  output int                           results_checked,
  output int                           unlisted_seen,
  output int                           fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       quality;
    gpcc_pkg::phase_t phase;
    logic             left_evt;
    logic             right_evt;
    logic             bad;
  } gait_result_t;

  gpcc_pkg::win_t   strike_win;
  gpcc_pkg::win_t   break_win;
  gpcc_pkg::phase_t gait;
  gpcc_pkg::time_t  last_strike;
  gpcc_pkg::time_t  last_break;

  gait_result_t awaited[$];

  // A timestamp earlier than the event counts as inside its window.
  function automatic logic in_window(input gpcc_pkg::time_t now,
                                     input gpcc_pkg::time_t mark,
                                     input gpcc_pkg::win_t width);
    if (now < mark) return 1'b1;
    return (now - mark) < width;
  endfunction

  // Advance the phase machine by one sample and form the result it gives.
  function automatic gait_result_t step_gait(input gpcc_pkg::time_t t,
                                             input gpcc_pkg::contact_t c);
    gait_result_t res;
    logic strike_hit;
    logic break_hit;
    res.bad = 1'b0;
    case (gait)
      gpcc_pkg::PH_L_STAND: begin
        if (c.l && !c.rs) begin
          gait = gpcc_pkg::PH_L_BREAK;
          last_break = t;
        end else if (!c.ls && c.r) begin
          gait = gpcc_pkg::PH_R_BREAK;
          last_break = t;
        end else if (!(c.l && c.r)) begin
          res.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_L_BREAK: begin
        if (c.l && !c.r) gait = gpcc_pkg::PH_L_SWING;
        else if (c.l && c.rs) gait = gpcc_pkg::PH_L_STAND;
        else if (!(c.l && !c.rs)) res.bad = 1'b1;
      end
      gpcc_pkg::PH_L_SWING: begin
        if (c.l && c.r) begin
          gait = gpcc_pkg::PH_L_STRIKE;
          last_strike = t;
        end else if (!(c.l && !c.r)) begin
          res.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_L_STRIKE: begin
        if (c.l && c.rs) gait = gpcc_pkg::PH_L_STAND;
        else if (!(c.l && !c.rs)) res.bad = 1'b1;
      end
      gpcc_pkg::PH_R_STAND: begin
        if (!c.ls && c.r) begin
          gait = gpcc_pkg::PH_R_BREAK;
          last_break = t;
        end else if (c.l && !c.rs) begin
          gait = gpcc_pkg::PH_L_BREAK;
          last_break = t;
        end else if (!(c.l && c.r)) begin
          res.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_R_BREAK: begin
        if (!c.l && c.r) gait = gpcc_pkg::PH_R_SWING;
        else if (c.ls && c.r) gait = gpcc_pkg::PH_R_STAND;
        else if (!(!c.ls && c.r)) res.bad = 1'b1;
      end
      gpcc_pkg::PH_R_SWING: begin
        if (c.l && c.r) begin
          gait = gpcc_pkg::PH_R_STRIKE;
          last_strike = t;
        end else if (!(!c.l && c.r)) begin
          res.bad = 1'b1;
        end
      end
      gpcc_pkg::PH_R_STRIKE: begin
        if (c.ls && c.r) gait = gpcc_pkg::PH_R_STAND;
        else if (!(!c.ls && c.r)) res.bad = 1'b1;
      end
      default: begin
        if (c.l && c.r) gait = gpcc_pkg::PH_L_STAND;
      end
    endcase

    strike_hit = in_window(t, last_strike, strike_win);
    break_hit  = in_window(t, last_break, break_win);
    res.phase = gait;
    res.quality = strike_hit ? gpcc_pkg::QUAL_UNUSABLE :
                  (break_hit ? gpcc_pkg::QUAL_INACCURATE : gpcc_pkg::QUAL_ACCURATE);
    // Recent events go to the far foot while the left foot leads.
    res.right_evt = (strike_hit || break_hit) && (gait < gpcc_pkg::PH_R_STAND);
    res.left_evt  = (strike_hit || break_hit) && !(gait < gpcc_pkg::PH_R_STAND);
    return res;
  endfunction

  function automatic int field_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    gait_result_t       want;
    gait_result_t       predicted;
    gpcc_pkg::contact_t flags;
    int                 errs;
    errs = 0;
    if (rst) begin
      strike_win  = gpcc_pkg::STRIKE_BLACKOUT_RST;
      break_win   = gpcc_pkg::BREAK_BLACKOUT_RST;
      gait        = gpcc_pkg::PH_UNKNOWN;
      last_strike = '0;
      last_break  = '0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gpcc_pkg::REG_STRIKE_BLACKOUT: strike_win = cfg_data;
          gpcc_pkg::REG_BREAK_BLACKOUT:  break_win  = cfg_data;
          default: ;
        endcase
      end

      // Retire the oldest prediction against the result taken this edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          errs++;
        end else begin
          want = awaited.pop_front();
          errs += field_mismatch("odometry_quality", want.quality, m_axis_tdata[1:0]);
          errs += field_mismatch("gait_phase", want.phase, m_axis_tdata[5:2]);
          errs += field_mismatch("recent_left_event", want.left_evt, m_axis_tdata[6]);
          errs += field_mismatch("recent_right_event", want.right_evt, m_axis_tdata[7]);
          errs += field_mismatch("unexpected_combination", want.bad, m_axis_tdata[8]);
          results_checked <= results_checked + 1;
          if (want.bad) unlisted_seen <= unlisted_seen + 1;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        flags.l  = s_axis_tdata[gpcc_pkg::TimeW];
        flags.r  = s_axis_tdata[gpcc_pkg::TimeW+1];
        flags.ls = s_axis_tdata[gpcc_pkg::TimeW+2];
        flags.rs = s_axis_tdata[gpcc_pkg::TimeW+3];
        predicted = step_gait(s_axis_tdata[gpcc_pkg::TimeW-1:0], flags);
        awaited.insert(awaited.size(), predicted);
      end
    end
    pending    <= awaited.size();
    fail_count <= fail_count + errs;
  end

endmodule

// ----- test/tb_gait_phase_contact_classifier_core.sv -----
// ---------------------------------------------------------------------------
// tb_gait_phase_contact_classifier_core
// Stimulus and verdict for the gait phase contact classifier core.
// A directed walk visits every phase transition, an unlisted flag case in each
// phase, backward and full-scale timestamps; then randomized strides with noise
// run under several blackout window settings, with both stream sides idling at
// random in all but one. A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_gait_phase_contact_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Unmapped register index: writes to it must be dropped.
  localparam logic [gpcc_pkg::CfgIdxW-1:0] REG_SPARE = 8'hFF;
  localparam int HOLD_OFF_CYCLES = 64;   // long receiver hold-off
  localparam int HOLD_OFF_AFTER  = 150;  // results seen before the hold-off
  localparam int SETTLE_CYCLES   = 8;    // settling wait for the two-stage pipeline
  localparam int DRAIN_LIMIT     = 2000;
  localparam int WALK_ITEMS      = 100;

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [71:0]                  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [15:0]                  m_axis_tdata;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [gpcc_pkg::CfgIdxW-1:0] cfg_index;
  logic [gpcc_pkg::WinW-1:0]    cfg_data;

  int pending;
  int results_checked;
  int unlisted_seen;
  int fail_count;

  bit              calm;          // when set, neither side idles
  gpcc_pkg::time_t now_us;        // running sample timestamp
  int              samples_sent;
  int              window_sets;

  gait_phase_contact_classifier_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  gait_result_checker i_results (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .results_checked (results_checked),
    .unlisted_seen   (unlisted_seen),
    .fail_count      (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: accept most cycles, drop ready now and then, and once hold
  // it low for a long stretch so the core fills up and stalls its input.
  initial begin : result_sink
    bit held_off;
    held_off = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !held_off && results_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  // Offer one request and hold it until it is taken. Idle gaps come first,
  // so they also fall right after an accept.
  task automatic push_sample(input gpcc_pkg::time_t t, input gpcc_pkg::contact_t c);
    while (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, c.rs, c.ls, c.r, c.l, t};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [gpcc_pkg::CfgIdxW-1:0] idx,
                           input gpcc_pkg::win_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Change windows only with the pipeline empty. The spare index gets junk
  // that must not land in either window.
  task automatic load_windows(input gpcc_pkg::win_t strike, input gpcc_pkg::win_t brk);
    drain_results();
    write_reg(gpcc_pkg::REG_STRIKE_BLACKOUT, strike);
    write_reg(gpcc_pkg::REG_BREAK_BLACKOUT, brk);
    write_reg(REG_SPARE, gpcc_pkg::win_t'($urandom));
    cfg_valid <= 1'b0;
    window_sets++;
  endtask

  // Mostly forward steps, some tiny ones to land near window edges, some
  // backward, and a few jumps anywhere in the 63-bit range.
  task automatic advance_time;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) now_us = gpcc_pkg::time_t'({$urandom, $urandom});
    else if (pick < 8) now_us = now_us - gpcc_pkg::time_t'($urandom_range(0, 300000));
    else if (pick < 30) now_us = now_us + gpcc_pkg::time_t'($urandom_range(0, 40));
    else now_us = now_us + gpcc_pkg::time_t'($urandom_range(0, 500000));
  endtask

  // Flags of one stride step, written {left weak, right weak, left strong,
  // right strong}: break contact, swing, heel strike, back to double stance.
  function automatic gpcc_pkg::contact_t stride_step(input bit right_primary, input int k);
    case (k)
      0:       return right_primary ? 4'b0101 : 4'b1110;
      1:       return right_primary ? 4'b0101 : 4'b1010;
      2:       return right_primary ? 4'b1101 : 4'b1110;
      default: return 4'b1111;
    endcase
  endfunction

  // Walk in strides with random holds on each step; mix in random flag
  // noise that breaks the pattern and exercises the unlisted cases.
  task automatic run_walk(input int n_items);
    int                 sent;
    int                 kind;
    int                 k;
    bit                 right_primary;
    gpcc_pkg::contact_t noise;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        advance_time();
        noise = 4'($urandom_range(0, 15));
        push_sample(now_us, noise);
        sent++;
      end else begin
        right_primary = (kind >= 57);
        for (k = 0; k < 4 && sent < n_items; k++) begin
          repeat ($urandom_range(1, 3)) begin
            advance_time();
            push_sample(now_us, stride_step(right_primary, k));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    int spins;
    rst           = 1'b1;
    calm          = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    now_us        = '0;
    samples_sent  = 0;
    window_sets   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed walk under the reset windows. Unknown phase holds without a
    // flag, then every transition and an unlisted case of each phase.
    push_sample(63'd0,      4'b0000);  // unknown holds
    push_sample(63'd20,     4'b1111);  // both weak: left stand
    push_sample(63'd40,     4'b0000);  // unlisted in left stand
    push_sample(63'd100000, 4'b1110);  // left break
    push_sample(63'd100020, 4'b0100);  // unlisted in left break
    push_sample(63'd100030, 4'b1010);  // left swing
    push_sample(63'd100050, 4'b0101);  // unlisted in left swing
    push_sample(63'd150000, 4'b1110);  // left strike
    push_sample(63'd150020, 4'b0101);  // unlisted in left strike
    push_sample(63'd300000, 4'b1111);  // back to left stand
    push_sample(63'd400000, 4'b0101);  // right break from left stand
    push_sample(63'd400010, 4'b1101);  // hold right break
    push_sample(63'd400020, 4'b1010);  // unlisted in right break
    push_sample(63'd400030, 4'b0101);  // right swing
    push_sample(63'd400050, 4'b1010);  // unlisted in right swing
    push_sample(63'd500000, 4'b1101);  // right strike
    push_sample(63'd500020, 4'b1010);  // unlisted in right strike
    push_sample(63'd600000, 4'b1111);  // right stand
    push_sample(63'd600020, 4'b0000);  // unlisted in right stand
    push_sample(63'd700000, 4'b1110);  // left break from right stand
    push_sample(63'd700010, 4'b1111);  // left stand straight from left break
    push_sample(63'd800000, 4'b0101);  // right break
    push_sample(63'd800010, 4'b1111);  // right stand straight from right break
    push_sample(63'd800020, 4'b0101);  // right break from right stand
    push_sample(63'd50,     4'b0101);  // time runs backwards: inside both windows
    push_sample('1,         4'b1101);  // strike at the largest timestamp
    push_sample(63'd0,      4'b1101);  // backwards again, hold right strike
    now_us = 63'd1000000;

    // Empty windows: quality must read accurate except where time runs backwards.
    load_windows('0, '0);
    run_walk(WALK_ITEMS);

    // Full-scale windows; the long receiver hold-off lands in this phase.
    load_windows('1, '1);
    run_walk(WALK_ITEMS);

    // Mid-range windows with no idling on either side.
    load_windows(gpcc_pkg::win_t'($urandom_range(1, 200000)),
                 gpcc_pkg::win_t'($urandom_range(1, 2000000)));
    calm <= 1'b1;
    run_walk(WALK_ITEMS);

    // Strike window anywhere in range, break window narrow.
    load_windows(gpcc_pkg::win_t'($urandom_range(0, 24'hFFFFFF)),
                 gpcc_pkg::win_t'($urandom_range(0, 1000)));
    calm <= 1'b0;
    run_walk(WALK_ITEMS);

    // Back to the power-on windows.
    load_windows(gpcc_pkg::STRIKE_BLACKOUT_RST, gpcc_pkg::BREAK_BLACKOUT_RST);
    run_walk(WALK_ITEMS);

    // Let the last results out, then wait SETTLE_CYCLES more for stray ones.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    spins = 0;
    while (pending != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d predicted results never arrived", pending);

    $display("Walked %0d contact samples through every gait phase under %0d window settings.",
             samples_sent, window_sets);
    $display("Checked %0d results, %0d of them unlisted flag combinations.",
             results_checked, unlisted_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/gpcc_pkg.sv
design/gpcc_phase_step.sv
design/gait_phase_contact_classifier_core.sv
test/gait_result_checker.sv
test/tb_gait_phase_contact_classifier_core.sv
